// ===== sv/tds_pkg.sv =====
package tds_pkg;

	// sizes
	localparam int MAX_CELLS = 256;
	localparam int MIN_CELLS = 3;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int IDX_W     = $clog2(MAX_CELLS + 1);
	localparam int ADDR_W    = $clog2(MAX_CELLS);
	localparam int PROD_W    = 2 * DATA_W;
	localparam int RND_W     = PROD_W - FRAC_BITS;
	localparam int ACC_W     = RND_W + 2;
	localparam int DIV_STEPS = DATA_W + FRAC_BITS;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int APB_W     = 32;
	localparam int PADDR_W   = 5;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [RND_W-1:0]  rnd_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [IDX_W-1:0]         idx_t;

	localparam data_t DATA_MAX = data_t'({1'b0, {(DATA_W-1){1'b1}}});
	localparam data_t DATA_MIN = data_t'({1'b1, {(DATA_W-1){1'b0}}});
	localparam data_t ONE_Q    = data_t'(1 << FRAC_BITS);

	// register map
	typedef enum logic [2:0] {
		REG_IMPL_LOWER,
		REG_IMPL_MIDDLE,
		REG_IMPL_UPPER,
		REG_EXPL_LOWER,
		REG_EXPL_MIDDLE,
		REG_EXPL_UPPER,
		REG_CELLS_IN_USE,
		REG_PROBE_CELL
	} reg_idx_t;

	typedef struct packed {
		data_t impl_lower;
		data_t impl_middle;
		data_t impl_upper;
		data_t expl_lower;
		data_t expl_middle;
		data_t expl_upper;
		idx_t  cells_in_use;
		idx_t  probe_cell;
	} cfg_t;

	// datapath operations
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLEAR,
		OP_ACC_CLR,
		OP_PRD_RD,
		OP_TERM_MUL,
		OP_TERM_ACC,
		OP_ROW_FIRST,
		OP_DIV_M,
		OP_MUL_D,
		OP_ROW_D,
		OP_MUL_R,
		OP_ROW_R,
		OP_DIV_LAST,
		OP_WR_P,
		OP_RD_RD,
		OP_MUL_U,
		OP_DIV_B,
		OP_SURF,
		OP_PROBE_RD,
		OP_OUT
	} op_t;

	typedef enum logic [1:0] {
		TERM_LOWER,
		TERM_MIDDLE,
		TERM_UPPER,
		TERM_SURF
	} term_t;

	typedef struct packed {
		op_t   op;
		idx_t  idx;
		term_t term;
	} cmd_t;

	typedef struct packed {
		logic start;
		idx_t n_cells;
		logic div_done;
	} sts_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECIDE,
		S_TERM_RD,
		S_TERM_MUL,
		S_TERM_ACC,
		S_ROW_FIRST,
		S_DIV_M,
		S_DIV_M_W,
		S_MUL_D,
		S_ROW_D,
		S_MUL_R,
		S_ROW_R,
		S_NEXT_ROW,
		S_DIV_LAST,
		S_DIV_LAST_W,
		S_WR_P,
		S_RD_RD,
		S_MUL_U,
		S_DIV_B,
		S_DIV_B_W,
		S_SURF,
		S_PROBE_RD,
		S_PROBE_OUT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		D_IDLE,
		D_RUN,
		D_FIN
	} div_state_t;

	// round a full product to nearest, ties up
	function automatic rnd_t qround(input prod_t p);
		prod_t t;
		t = p + (prod_t'(1) <<< (FRAC_BITS - 1));
		return t[PROD_W-1:FRAC_BITS];
	endfunction

	function automatic acc_t ext_data(input data_t x);
		return {{(ACC_W-DATA_W){x[DATA_W-1]}}, x};
	endfunction

	function automatic acc_t ext_rnd(input rnd_t x);
		return {{(ACC_W-RND_W){x[RND_W-1]}}, x};
	endfunction

	// saturate a wide sum to the data width
	function automatic data_t sat_acc(input acc_t x);
		data_t r;
		if ((&x[ACC_W-1:DATA_W-1]) || !(|x[ACC_W-1:DATA_W-1])) begin
			r = x[DATA_W-1:0];
		end else if (x[ACC_W-1]) begin
			r = DATA_MIN;
		end else begin
			r = DATA_MAX;
		end
		return r;
	endfunction

endpackage

// ===== sv/tds_div.sv =====
module tds_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  tds_pkg::data_t      a,
	input  tds_pkg::data_t      b,
	output logic                done,
	output tds_pkg::data_t      q
);

	localparam int NUM_W = tds_pkg::DIV_STEPS;
	localparam int W     = tds_pkg::DATA_W;

	tds_pkg::div_state_t state_q;
	logic [tds_pkg::CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] den_q;
	logic neg_q, zero_q, aneg_q, anz_q;
	tds_pkg::data_t q_q;
	logic done_q;

	logic [W-1:0] a_mag, b_mag;
	logic [W:0] rem_sh, diff;
	tds_pkg::data_t res;

	assign a_mag = a[W-1] ? (~a + W'(1)) : a;
	assign b_mag = b[W-1] ? (~b + W'(1)) : b;

	// one quotient bit per cycle
	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};

	// sign and saturation of the final quotient
	always_comb begin
		if (zero_q) begin
			res = aneg_q ? tds_pkg::DATA_MIN : (anz_q ? tds_pkg::DATA_MAX : '0);
		end else if (!neg_q) begin
			res = (|num_q[NUM_W-1:W-1]) ? tds_pkg::DATA_MAX : num_q[W-1:0];
		end else if ((|num_q[NUM_W-1:W]) || (num_q[W-1] && (|num_q[W-2:0]))) begin
			res = tds_pkg::DATA_MIN;
		end else begin
			res = ~num_q[W-1:0] + W'(1);
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tds_pkg::D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				tds_pkg::D_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						state_q <= (b == '0) ? tds_pkg::D_FIN : tds_pkg::D_RUN;
					end
				end
				tds_pkg::D_RUN: begin
					cnt_q <= cnt_q + tds_pkg::CNT_W'(1);
					if (cnt_q == tds_pkg::CNT_W'(NUM_W - 1)) begin
						state_q <= tds_pkg::D_FIN;
					end
				end
				tds_pkg::D_FIN: begin
					done_q  <= 1'b1;
					state_q <= tds_pkg::D_IDLE;
				end
				default: state_q <= tds_pkg::D_IDLE;
			endcase
		end
	end

	// operands and quotient
	always_ff @(posedge clk) begin
		if (state_q == tds_pkg::D_IDLE && start) begin
			num_q  <= {a_mag, {tds_pkg::FRAC_BITS{1'b0}}};
			den_q  <= b_mag;
			rem_q  <= '0;
			neg_q  <= a[W-1] ^ b[W-1];
			zero_q <= (b == '0);
			aneg_q <= a[W-1];
			anz_q  <= (a != '0);
		end else if (state_q == tds_pkg::D_RUN) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				num_q <= {num_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[W-1:0];
				num_q <= {num_q[NUM_W-2:0], 1'b0};
			end
		end
		if (state_q == tds_pkg::D_FIN) begin
			q_q <= res;
		end
	end

	assign done = done_q;
	assign q    = q_q;

endmodule

// ===== sv/tds_dp.sv =====
module tds_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  tds_pkg::cfg_t       cfg,
	input  tds_pkg::cmd_t       cmd,
	input  logic                start_req,
	input  tds_pkg::data_t      surface_value,
	output tds_pkg::sts_t       sts,
	output tds_pkg::data_t      probe_value
);

	localparam int AW = tds_pkg::ADDR_W;
	localparam int IW = tds_pkg::IDX_W;

	// stores: interior profile, modified rhs and diagonal
	tds_pkg::data_t prof_mem [tds_pkg::MAX_CELLS];
	tds_pkg::data_t rhs_mem  [tds_pkg::MAX_CELLS];
	tds_pkg::data_t diag_mem [tds_pkg::MAX_CELLS];
	logic [tds_pkg::MAX_CELLS-1:0] valid_q;

	tds_pkg::data_t s_q, surf_q, d_q, r_q, pn_q, pdata_q, rr_q, dd_q, out_q;
	logic start_q, pvalid_q, sub_q;
	tds_pkg::idx_t n_q, p_q;
	tds_pkg::acc_t acc_q;
	tds_pkg::prod_t prod_q;

	tds_pkg::idx_t n_clamp, p_clamp;
	tds_pkg::data_t coef, operand, raw, d_new, r_new, num_b;
	tds_pkg::data_t mul_a, mul_b, div_a, div_b, div_q;
	tds_pkg::rnd_t prod_rnd;
	logic div_start, div_done;
	logic [AW-1:0] p_rd_addr, p_wr_addr, rd_addr;

	// clamp cell count and probe
	always_comb begin
		if (cfg.cells_in_use < IW'(tds_pkg::MIN_CELLS)) begin
			n_clamp = IW'(tds_pkg::MIN_CELLS);
		end else if (cfg.cells_in_use > IW'(tds_pkg::MAX_CELLS)) begin
			n_clamp = IW'(tds_pkg::MAX_CELLS);
		end else begin
			n_clamp = cfg.cells_in_use;
		end
		p_clamp = (cfg.probe_cell > n_clamp) ? n_clamp : cfg.probe_cell;
	end

	// right-hand side term selection
	always_comb begin
		unique case (cmd.term)
			tds_pkg::TERM_LOWER:  coef = cfg.expl_lower;
			tds_pkg::TERM_MIDDLE: coef = cfg.expl_middle;
			tds_pkg::TERM_UPPER:  coef = cfg.expl_upper;
			tds_pkg::TERM_SURF:   coef = cfg.impl_lower;
			default:              coef = cfg.expl_lower;
		endcase
		if (cmd.term == tds_pkg::TERM_SURF) begin
			operand = s_q;
		end else if (cmd.idx == '0) begin
			operand = surf_q;
		end else if (cmd.idx > n_q) begin
			operand = '0;
		end else begin
			operand = pvalid_q ? pdata_q : '0;
		end
	end

	// shared multiplier operands
	always_comb begin
		unique case (cmd.op)
			tds_pkg::OP_MUL_D: begin
				mul_a = div_q;
				mul_b = cfg.impl_upper;
			end
			tds_pkg::OP_MUL_R: begin
				mul_a = div_q;
				mul_b = r_q;
			end
			tds_pkg::OP_MUL_U: begin
				mul_a = cfg.impl_upper;
				mul_b = pn_q;
			end
			default: begin
				mul_a = coef;
				mul_b = operand;
			end
		endcase
	end

	assign prod_rnd = tds_pkg::qround(prod_q);
	assign raw      = tds_pkg::sat_acc(acc_q);
	assign d_new    = tds_pkg::sat_acc(tds_pkg::ext_data(cfg.impl_middle)
		- tds_pkg::ext_rnd(prod_rnd));
	assign r_new    = tds_pkg::sat_acc(tds_pkg::ext_data(raw) - tds_pkg::ext_rnd(prod_rnd));
	assign num_b    = tds_pkg::sat_acc(tds_pkg::ext_data(rr_q) - tds_pkg::ext_rnd(prod_rnd));

	// divider operands
	always_comb begin
		div_start = 1'b1;
		unique case (cmd.op)
			tds_pkg::OP_DIV_M: begin
				div_a = cfg.impl_lower;
				div_b = d_q;
			end
			tds_pkg::OP_DIV_LAST: begin
				div_a = r_q;
				div_b = d_q;
			end
			tds_pkg::OP_DIV_B: begin
				div_a = num_b;
				div_b = dd_q;
			end
			default: begin
				div_start = 1'b0;
				div_a     = r_q;
				div_b     = d_q;
			end
		endcase
	end

	tds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (div_a),
		.b      (div_b),
		.done   (div_done),
		.q      (div_q)
	);

	assign p_wr_addr = AW'(cmd.idx - IW'(1));
	assign p_rd_addr = AW'(p_q - IW'(1));
	assign rd_addr   = (cmd.op == tds_pkg::OP_PROBE_RD) ? p_rd_addr : p_wr_addr;

	// item state and surface cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
			n_q     <= IW'(tds_pkg::MAX_CELLS);
			p_q     <= '0;
			surf_q  <= '0;
			valid_q <= '0;
		end else begin
			if (cmd.op == tds_pkg::OP_LOAD) begin
				start_q <= start_req;
				n_q     <= n_clamp;
				p_q     <= p_clamp;
			end
			if (cmd.op == tds_pkg::OP_CLEAR) begin
				valid_q <= '0;
			end
			if (cmd.op == tds_pkg::OP_WR_P) begin
				valid_q[p_wr_addr] <= 1'b1;
			end
			if (cmd.op == tds_pkg::OP_CLEAR || cmd.op == tds_pkg::OP_SURF) begin
				surf_q <= s_q;
			end
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.op == tds_pkg::OP_LOAD) begin
			s_q <= surface_value;
		end
		if (cmd.op == tds_pkg::OP_TERM_MUL) begin
			sub_q <= (cmd.term == tds_pkg::TERM_SURF);
		end
		if (cmd.op == tds_pkg::OP_TERM_MUL || cmd.op == tds_pkg::OP_MUL_D
			|| cmd.op == tds_pkg::OP_MUL_R || cmd.op == tds_pkg::OP_MUL_U) begin
			prod_q <= mul_a * mul_b;
		end
		unique case (cmd.op)
			tds_pkg::OP_ACC_CLR:  acc_q <= '0;
			tds_pkg::OP_TERM_ACC: begin
				acc_q <= sub_q ? acc_q - tds_pkg::ext_rnd(prod_rnd)
					: acc_q + tds_pkg::ext_rnd(prod_rnd);
			end
			default: ;
		endcase
		if (cmd.op == tds_pkg::OP_ROW_FIRST) begin
			d_q <= cfg.impl_middle;
			r_q <= raw;
		end
		if (cmd.op == tds_pkg::OP_ROW_D) begin
			d_q <= d_new;
		end
		if (cmd.op == tds_pkg::OP_ROW_R) begin
			r_q <= r_new;
		end
		if (cmd.op == tds_pkg::OP_WR_P) begin
			pn_q <= div_q;
		end
		if (cmd.op == tds_pkg::OP_OUT) begin
			out_q <= (p_q == '0) ? surf_q : (pvalid_q ? pdata_q : '0);
		end
	end

	// profile memory
	always_ff @(posedge clk) begin
		if (cmd.op == tds_pkg::OP_WR_P) begin
			prof_mem[p_wr_addr] <= div_q;
		end
		if (cmd.op == tds_pkg::OP_PRD_RD || cmd.op == tds_pkg::OP_PROBE_RD) begin
			pdata_q  <= prof_mem[rd_addr];
			pvalid_q <= valid_q[rd_addr];
		end
	end

	// modified rhs and diagonal memories
	always_ff @(posedge clk) begin
		if (cmd.op == tds_pkg::OP_ROW_FIRST) begin
			rhs_mem[AW'(cmd.idx)]  <= raw;
			diag_mem[AW'(cmd.idx)] <= cfg.impl_middle;
		end
		if (cmd.op == tds_pkg::OP_ROW_D) begin
			diag_mem[AW'(cmd.idx)] <= d_new;
		end
		if (cmd.op == tds_pkg::OP_ROW_R) begin
			rhs_mem[AW'(cmd.idx)] <= r_new;
		end
		if (cmd.op == tds_pkg::OP_RD_RD) begin
			rr_q <= rhs_mem[p_wr_addr];
			dd_q <= diag_mem[p_wr_addr];
		end
	end

	assign sts.start    = start_q;
	assign sts.n_cells  = n_q;
	assign sts.div_done = div_done;
	assign probe_value  = out_q;

endmodule

// ===== sv/tds_ctrl.sv =====
module tds_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  tds_pkg::sts_t       sts,
	output tds_pkg::cmd_t       cmd
);

	localparam int IW = tds_pkg::IDX_W;

	tds_pkg::ctrl_state_t state_q, state_d;
	tds_pkg::idx_t i_q, i_d;
	tds_pkg::term_t t_q, t_d;
	logic out_valid_q, set_out;

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tds_pkg::S_IDLE;
			i_q         <= '0;
			t_q         <= tds_pkg::TERM_LOWER;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			t_q     <= t_d;
			if (set_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		t_d      = t_q;
		in_ready = 1'b0;
		set_out  = 1'b0;
		cmd.op   = tds_pkg::OP_NONE;
		cmd.idx  = i_q;
		cmd.term = t_q;
		unique case (state_q)
			tds_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = tds_pkg::OP_LOAD;
					state_d = tds_pkg::S_DECIDE;
				end
			end
			tds_pkg::S_DECIDE: begin
				if (sts.start) begin
					cmd.op  = tds_pkg::OP_CLEAR;
					state_d = tds_pkg::S_PROBE_RD;
				end else begin
					cmd.op  = tds_pkg::OP_ACC_CLR;
					i_d     = '0;
					t_d     = tds_pkg::TERM_LOWER;
					state_d = tds_pkg::S_TERM_RD;
				end
			end
			tds_pkg::S_TERM_RD: begin
				cmd.op  = tds_pkg::OP_PRD_RD;
				cmd.idx = i_q + IW'(t_q);
				state_d = tds_pkg::S_TERM_MUL;
			end
			tds_pkg::S_TERM_MUL: begin
				cmd.op  = tds_pkg::OP_TERM_MUL;
				cmd.idx = i_q + IW'(t_q);
				state_d = tds_pkg::S_TERM_ACC;
			end
			tds_pkg::S_TERM_ACC: begin
				cmd.op = tds_pkg::OP_TERM_ACC;
				if (i_q == '0 && t_q == tds_pkg::TERM_SURF) begin
					state_d = tds_pkg::S_ROW_FIRST;
				end else if (i_q != '0 && t_q == tds_pkg::TERM_UPPER) begin
					state_d = tds_pkg::S_DIV_M;
				end else begin
					t_d     = tds_pkg::term_t'(t_q + 2'd1);
					state_d = tds_pkg::S_TERM_RD;
				end
			end
			tds_pkg::S_ROW_FIRST: begin
				cmd.op  = tds_pkg::OP_ROW_FIRST;
				state_d = tds_pkg::S_NEXT_ROW;
			end
			tds_pkg::S_DIV_M: begin
				cmd.op  = tds_pkg::OP_DIV_M;
				state_d = tds_pkg::S_DIV_M_W;
			end
			tds_pkg::S_DIV_M_W: begin
				if (sts.div_done) begin
					state_d = tds_pkg::S_MUL_D;
				end
			end
			tds_pkg::S_MUL_D: begin
				cmd.op  = tds_pkg::OP_MUL_D;
				state_d = tds_pkg::S_ROW_D;
			end
			tds_pkg::S_ROW_D: begin
				cmd.op  = tds_pkg::OP_ROW_D;
				state_d = tds_pkg::S_MUL_R;
			end
			tds_pkg::S_MUL_R: begin
				cmd.op  = tds_pkg::OP_MUL_R;
				state_d = tds_pkg::S_ROW_R;
			end
			tds_pkg::S_ROW_R: begin
				cmd.op  = tds_pkg::OP_ROW_R;
				state_d = tds_pkg::S_NEXT_ROW;
			end
			tds_pkg::S_NEXT_ROW: begin
				cmd.op = tds_pkg::OP_ACC_CLR;
				t_d    = tds_pkg::TERM_LOWER;
				if (i_q == sts.n_cells - IW'(1)) begin
					state_d = tds_pkg::S_DIV_LAST;
				end else begin
					i_d     = i_q + IW'(1);
					state_d = tds_pkg::S_TERM_RD;
				end
			end
			tds_pkg::S_DIV_LAST: begin
				cmd.op  = tds_pkg::OP_DIV_LAST;
				i_d     = sts.n_cells;
				state_d = tds_pkg::S_DIV_LAST_W;
			end
			tds_pkg::S_DIV_LAST_W: begin
				if (sts.div_done) begin
					state_d = tds_pkg::S_WR_P;
				end
			end
			tds_pkg::S_WR_P: begin
				cmd.op = tds_pkg::OP_WR_P;
				if (i_q == IW'(1)) begin
					state_d = tds_pkg::S_SURF;
				end else begin
					i_d     = i_q - IW'(1);
					state_d = tds_pkg::S_RD_RD;
				end
			end
			tds_pkg::S_RD_RD: begin
				cmd.op  = tds_pkg::OP_RD_RD;
				state_d = tds_pkg::S_MUL_U;
			end
			tds_pkg::S_MUL_U: begin
				cmd.op  = tds_pkg::OP_MUL_U;
				state_d = tds_pkg::S_DIV_B;
			end
			tds_pkg::S_DIV_B: begin
				cmd.op  = tds_pkg::OP_DIV_B;
				state_d = tds_pkg::S_DIV_B_W;
			end
			tds_pkg::S_DIV_B_W: begin
				if (sts.div_done) begin
					state_d = tds_pkg::S_WR_P;
				end
			end
			tds_pkg::S_SURF: begin
				cmd.op  = tds_pkg::OP_SURF;
				state_d = tds_pkg::S_PROBE_RD;
			end
			tds_pkg::S_PROBE_RD: begin
				cmd.op  = tds_pkg::OP_PROBE_RD;
				state_d = tds_pkg::S_PROBE_OUT;
			end
			tds_pkg::S_PROBE_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = tds_pkg::OP_OUT;
					set_out = 1'b1;
					state_d = tds_pkg::S_IDLE;
				end
			end
			default: state_d = tds_pkg::S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/tridiagonal_diffusion_step_top.sv =====
// Diffusion step engine: one input transaction per time step.
// Input channel (in_valid/in_ready) carries start_req and surface_value;
// output channel (out_valid/out_ready) returns probe_value, one result per
// input transaction. Coefficients, cell count and probe cell are to be written
// through the APB port only while the engine is idle; the block itself does
// not enforce this, and pready is always high.
// A start transaction clears the profile and loads the surface cell; its
// result is read at the probe cell and then registered for output. A solve
// transaction runs a forward sweep (three multiply-accumulates per row, four
// on the first row, then on every later row one divide and two multiplies)
// and a backward sweep (one multiply and one divide per cell). The shared
// bit-serial divider serves every divide, skips straight to its final state
// for a zero divisor and sets the rate; one transaction is in flight at a
// time, and in_ready is high only when the engine is idle.
// A finished result sits in the output register until taken; the engine
// accepts the next transaction meanwhile and holds its own result back
// until the output register is free. Reset restores the register defaults
// and clears the profile to zero through per-cell valid bits.
module tridiagonal_diffusion_step_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tds_pkg::PADDR_W-1:0]  paddr,
	input  logic [tds_pkg::APB_W-1:0]    pwdata,
	output logic [tds_pkg::APB_W-1:0]    prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         start_req,
	input  logic signed [31:0]           surface_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [31:0]           probe_value
);

	localparam int IW = tds_pkg::IDX_W;

	tds_pkg::cfg_t cfg_q;
	tds_pkg::cmd_t cmd;
	tds_pkg::sts_t sts;
	tds_pkg::reg_idx_t reg_sel;
	logic wr_en;

	assign pready  = 1'b1;
	assign reg_sel = tds_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en   = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.impl_lower   <= '0;
			cfg_q.impl_middle  <= tds_pkg::ONE_Q;
			cfg_q.impl_upper   <= '0;
			cfg_q.expl_lower   <= '0;
			cfg_q.expl_middle  <= tds_pkg::ONE_Q;
			cfg_q.expl_upper   <= '0;
			cfg_q.cells_in_use <= IW'(tds_pkg::MAX_CELLS);
			cfg_q.probe_cell   <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				tds_pkg::REG_IMPL_LOWER:   cfg_q.impl_lower   <= pwdata;
				tds_pkg::REG_IMPL_MIDDLE:  cfg_q.impl_middle  <= pwdata;
				tds_pkg::REG_IMPL_UPPER:   cfg_q.impl_upper   <= pwdata;
				tds_pkg::REG_EXPL_LOWER:   cfg_q.expl_lower   <= pwdata;
				tds_pkg::REG_EXPL_MIDDLE:  cfg_q.expl_middle  <= pwdata;
				tds_pkg::REG_EXPL_UPPER:   cfg_q.expl_upper   <= pwdata;
				tds_pkg::REG_CELLS_IN_USE: cfg_q.cells_in_use <= pwdata[IW-1:0];
				tds_pkg::REG_PROBE_CELL:   cfg_q.probe_cell   <= pwdata[IW-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_sel)
			tds_pkg::REG_IMPL_LOWER:   prdata = cfg_q.impl_lower;
			tds_pkg::REG_IMPL_MIDDLE:  prdata = cfg_q.impl_middle;
			tds_pkg::REG_IMPL_UPPER:   prdata = cfg_q.impl_upper;
			tds_pkg::REG_EXPL_LOWER:   prdata = cfg_q.expl_lower;
			tds_pkg::REG_EXPL_MIDDLE:  prdata = cfg_q.expl_middle;
			tds_pkg::REG_EXPL_UPPER:   prdata = cfg_q.expl_upper;
			tds_pkg::REG_CELLS_IN_USE: prdata = {{(tds_pkg::APB_W-IW){1'b0}}, cfg_q.cells_in_use};
			tds_pkg::REG_PROBE_CELL:   prdata = {{(tds_pkg::APB_W-IW){1'b0}}, cfg_q.probe_cell};
			default:                   prdata = '0;
		endcase
	end

	tds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tds_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.start_req     (start_req),
		.surface_value (surface_value),
		.sts           (sts),
		.probe_value   (probe_value)
	);

	// one transaction in flight: ready drops right after acceptance
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a transaction is in flight");

	// divider completion is a single-cycle pulse
	a_div_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |=> !sts.div_done)
		else $error("divider done held for more than one cycle");

	// clamped cell count stays in range
	a_cells_range: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.n_cells >= IW'(tds_pkg::MIN_CELLS)) && (sts.n_cells <= IW'(tds_pkg::MAX_CELLS)))
		else $error("cell count out of range");

endmodule
